// ----- rtl/stt_pkg.sv -----
// stt_pkg: shared types, constants and codes for the search transposition table
package stt_pkg;

    localparam int INDEX_BITS = 16;
    localparam int ADDR_BITS  = INDEX_BITS + 1;
    localparam int SLOTS      = 1 << ADDR_BITS;
    localparam int HASH_W     = 64;
    localparam int TAG_SHIFT  = 16;
    localparam int TAG_W      = HASH_W - TAG_SHIFT;
    localparam int AGE_W      = 3;
    localparam int SCORE_W    = 16;
    localparam int DEPTH_W    = 8;
    localparam int MOVE_W     = 16;
    localparam int MATE_W     = 15;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    typedef enum logic [1:0] {
        ACT_STORE  = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_EXACT = 2'd0,
        KIND_HIGH  = 2'd1,
        KIND_LOW   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_CURRENT_AGE = 2'd0,
        REG_MATE_SCORE  = 2'd1,
        REG_MATE_DEPTH  = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic [AGE_W-1:0]   current_age;
        logic [MATE_W-1:0]  mate_score;
        logic [DEPTH_W-1:0] mate_depth;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                action;
        logic                      side;
        logic [HASH_W-1:0]         hash_value;
        logic [DEPTH_W-1:0]        search_depth;
        logic [MOVE_W-1:0]         best_move;
        logic                      best_move_valid;
        logic signed [SCORE_W-1:0] score;
        logic signed [SCORE_W-1:0] window_low;
        logic signed [SCORE_W-1:0] window_high;
    } item_t;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic [TAG_W-1:0] tag;
    } meta_t;

    typedef struct packed {
        logic                      move_valid;
        logic [MOVE_W-1:0]         move;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
        logic [1:0]                kind;
    } info_t;

    typedef struct packed {
        logic                      hit;
        logic [1:0]                entry_kind;
        logic signed [SCORE_W-1:0] entry_score;
        logic [DEPTH_W-1:0]        entry_depth;
        logic [MOVE_W-1:0]         entry_move;
        logic                      entry_move_valid;
        logic                      was_replaced;
    } result_t;

    localparam int META_W = $bits(meta_t);
    localparam int INFO_W = $bits(info_t);

endpackage

// ----- rtl/stt_ram.sv -----
// stt_ram: generic single-write, single-read synchronous ram with registered read
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/stt_apb_regs.sv -----
// stt_apb_regs: apb configuration registers for age and mate handling
module stt_apb_regs
    import stt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_CURRENT_AGE: cfg_next.current_age = pwdata[AGE_W-1:0];
                REG_MATE_SCORE:  cfg_next.mate_score  = pwdata[MATE_W-1:0];
                REG_MATE_DEPTH:  cfg_next.mate_depth  = pwdata[DEPTH_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_age <= '0;
            cfg_reg.mate_score  <= MATE_W'(30000);
            cfg_reg.mate_depth  <= DEPTH_W'(255);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CURRENT_AGE: prdata = PDATA_W'(cfg_reg.current_age);
            REG_MATE_SCORE:  prdata = PDATA_W'(cfg_reg.mate_score);
            REG_MATE_DEPTH:  prdata = PDATA_W'(cfg_reg.mate_depth);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/stt_update.sv -----
// stt_update: replacement decision, score classification and write-back data
module stt_update
    import stt_pkg::*;
(
    input  item_t   item,
    input  meta_t   meta_rd,
    input  info_t   info_rd,
    input  cfg_t    cfg,
    output logic    meta_we,
    output meta_t   meta_wdata,
    output logic    info_we,
    output info_t   info_wdata,
    output result_t res
);

    logic signed [SCORE_W:0] s_ext;
    logic signed [SCORE_W:0] lo_ext;
    logic signed [SCORE_W:0] hi_ext;
    logic signed [SCORE_W:0] m_pos;
    logic signed [SCORE_W:0] m_neg;
    logic                    in_window;
    logic                    mate_up;
    logic                    mate_dn;
    logic                    replace;
    logic                    tag_match;
    logic [TAG_W-1:0]        item_tag;
    info_t                   new_info;

    assign s_ext    = {item.score[SCORE_W-1], item.score};
    assign lo_ext   = {item.window_low[SCORE_W-1], item.window_low};
    assign hi_ext   = {item.window_high[SCORE_W-1], item.window_high};
    assign m_pos    = signed'({2'b00, cfg.mate_score});
    assign m_neg    = -m_pos;
    assign in_window = (s_ext < hi_ext) && (s_ext > lo_ext);
    assign mate_up  = s_ext >= m_pos;
    assign mate_dn  = s_ext <= m_neg;
    assign item_tag = item.hash_value[HASH_W-1:TAG_SHIFT];
    assign tag_match = meta_rd.tag == item_tag;

    assign replace = (meta_rd.age != cfg.current_age)
                  || (item.search_depth > info_rd.depth)
                  || ((info_rd.kind != KIND_EXACT) && (in_window || mate_up || mate_dn));

    // classify the stored bound; a winning mate at or above the window or a losing mate at or below it becomes exact
    always_comb
    begin
        new_info.move_valid = item.best_move_valid;
        new_info.move       = item.best_move_valid ? item.best_move : '0;
        new_info.depth      = item.search_depth;
        new_info.score      = item.score;
        new_info.kind       = KIND_EXACT;
        if (!in_window)
        begin
            if (s_ext >= hi_ext)
            begin
                if (mate_up)
                begin
                    new_info.depth = cfg.mate_depth;
                end
                else
                begin
                    new_info.kind = KIND_HIGH;
                end
            end
            else if (mate_dn)
            begin
                new_info.depth = cfg.mate_depth;
            end
            else
            begin
                new_info.kind = KIND_LOW;
            end
        end
    end

    always_comb
    begin
        meta_we         = 1'b0;
        info_we         = 1'b0;
        meta_wdata.tag  = item_tag;
        meta_wdata.age  = cfg.current_age;
        info_wdata      = new_info;
        res             = '0;
        case (item.action)
            ACT_STORE:
            begin
                if (replace)
                begin
                    meta_we          = 1'b1;
                    info_we          = 1'b1;
                    res.was_replaced = 1'b1;
                end
            end
            ACT_LOOKUP:
            begin
                if (tag_match)
                begin
                    meta_we              = 1'b1;
                    res.hit              = 1'b1;
                    res.entry_kind       = info_rd.kind;
                    res.entry_score      = info_rd.score;
                    res.entry_depth      = info_rd.depth;
                    res.entry_move       = info_rd.move;
                    res.entry_move_valid = info_rd.move_valid;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

// ----- rtl/search_transposition_table.sv -----
// search_transposition_table: top level with control sequencer, table memories and result register
//
// Items arrive on the item channel (item_valid / item_stall) and each gives exactly
// one transfer on the result channel (result_valid / result_stall). An item is
// taken when item_valid is high and item_stall is low.
// Store and lookup: the slot is read at the accepting edge, modified and written
// back in the exec state, where the result register is loaded; item_stall stays
// high until then, so the next item is taken only after the write-back.
// Clear: the tag/age memory is swept one slot a cycle over all 2^(INDEX_BITS+1)
// slots (131072 at INDEX_BITS 16), then the result follows through the exec state.
// Rate is set by the single read-modify-write of the slot memories per item.
// After reset both memories are swept to zero while item_stall stays high;
// configuration writes over the apb port are taken at any time. While the receiver
// holds result_stall the result is kept and a finished item waits in its write-back
// cycle; a new item can be accepted while a result still waits to be taken.
// Configuration: current_age at 0x0, mate_score at 0x4, mate_depth at 0x8.
module search_transposition_table
    import stt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [1:0]                action,
    input  logic                      side,
    input  logic [HASH_W-1:0]         hash_value,
    input  logic [DEPTH_W-1:0]        search_depth,
    input  logic [MOVE_W-1:0]         best_move,
    input  logic                      best_move_valid,
    input  logic signed [SCORE_W-1:0] score,
    input  logic signed [SCORE_W-1:0] window_low,
    input  logic signed [SCORE_W-1:0] window_high,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic                      hit,
    output logic [1:0]                entry_kind,
    output logic signed [SCORE_W-1:0] entry_score,
    output logic [DEPTH_W-1:0]        entry_depth,
    output logic [MOVE_W-1:0]         entry_move,
    output logic                      entry_move_valid,
    output logic                      was_replaced
);

    cfg_t                 cfg;
    state_t               state_reg;
    state_t               state_next;
    logic [ADDR_BITS-1:0] sweep_reg;
    logic [ADDR_BITS-1:0] sweep_next;
    item_t                item_reg;
    result_t              res_reg;
    logic                 result_valid_reg;
    logic                 result_valid_next;

    logic                 accept;
    logic                 exec_fire;
    logic                 out_free;
    logic                 sweep_last;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [ADDR_BITS-1:0] item_addr;

    logic                 meta_we;
    logic [ADDR_BITS-1:0] meta_waddr;
    meta_t                meta_wdata;
    meta_t                meta_rd;
    logic                 info_we;
    logic [ADDR_BITS-1:0] info_waddr;
    info_t                info_wdata;
    info_t                info_rd;

    logic                 upd_meta_we;
    meta_t                upd_meta_wdata;
    logic                 upd_info_we;
    info_t                upd_info_wdata;
    result_t              upd_res;

    stt_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign item_stall = state_reg != ST_IDLE;
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;
    assign exec_fire  = (state_reg == ST_EXEC) && out_free;
    assign sweep_last = &sweep_reg;
    assign rd_addr    = {side, hash_value[INDEX_BITS-1:0]};
    assign item_addr  = {item_reg.side, item_reg.hash_value[INDEX_BITS-1:0]};

    stt_update u_update (
        .item       (item_reg),
        .meta_rd    (meta_rd),
        .info_rd    (info_rd),
        .cfg        (cfg),
        .meta_we    (upd_meta_we),
        .meta_wdata (upd_meta_wdata),
        .info_we    (upd_info_we),
        .info_wdata (upd_info_wdata),
        .res        (upd_res)
    );

    // write port steering for the sweeps and for write-back
    always_comb
    begin
        meta_we        = 1'b0;
        meta_waddr     = item_addr;
        meta_wdata     = upd_meta_wdata;
        info_we        = 1'b0;
        info_waddr     = item_addr;
        info_wdata     = upd_info_wdata;
        case (state_reg)
            ST_INIT:
            begin
                meta_we    = 1'b1;
                meta_waddr = sweep_reg;
                meta_wdata = '0;
                info_we    = 1'b1;
                info_waddr = sweep_reg;
                info_wdata = '0;
            end
            ST_CLEAR:
            begin
                meta_we        = 1'b1;
                meta_waddr     = sweep_reg;
                meta_wdata.tag = '0;
                meta_wdata.age = cfg.current_age - AGE_W'(1);
            end
            ST_EXEC:
            begin
                meta_we = exec_fire && upd_meta_we;
                info_we = exec_fire && upd_info_we;
            end
            default:
            begin
                meta_we = 1'b0;
                info_we = 1'b0;
            end
        endcase
    end

    stt_ram #(
        .WIDTH (META_W),
        .DEPTH (SLOTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (meta_rd)
    );

    stt_ram #(
        .WIDTH (INFO_W),
        .DEPTH (SLOTS)
    ) u_info_ram (
        .clk   (clk),
        .we    (info_we),
        .waddr (info_waddr),
        .wdata (info_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (info_rd)
    );

    always_comb
    begin
        state_next        = state_reg;
        sweep_next        = sweep_reg;
        result_valid_next = result_valid_reg && result_stall;
        case (state_reg)
            ST_INIT:
            begin
                sweep_next = sweep_reg + ADDR_BITS'(1);
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action == ACT_CLEAR) ? ST_CLEAR : ST_EXEC;
                end
            end
            ST_CLEAR:
            begin
                sweep_next = sweep_reg + ADDR_BITS'(1);
                if (sweep_last)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next        = ST_IDLE;
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            sweep_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action          <= action;
            item_reg.side            <= side;
            item_reg.hash_value      <= hash_value;
            item_reg.search_depth    <= search_depth;
            item_reg.best_move       <= best_move;
            item_reg.best_move_valid <= best_move_valid;
            item_reg.score           <= score;
            item_reg.window_low      <= window_low;
            item_reg.window_high     <= window_high;
        end
        if (exec_fire)
        begin
            res_reg <= upd_res;
        end
    end

    assign result_valid     = result_valid_reg;
    assign hit              = res_reg.hit;
    assign entry_kind       = res_reg.entry_kind;
    assign entry_score      = res_reg.entry_score;
    assign entry_depth      = res_reg.entry_depth;
    assign entry_move       = res_reg.entry_move;
    assign entry_move_valid = res_reg.entry_move_valid;
    assign was_replaced     = res_reg.was_replaced;

`ifndef SYNTHESIS
    a_exec_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> result_valid_reg && (state_reg == ST_IDLE))
        else $error("write-back did not load the result register");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !meta_we && !info_we)
        else $error("memory write while idle");

    a_sweep_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_EXEC) |-> (sweep_reg == '0))
        else $error("sweep counter not parked outside a sweep");

    a_hit_not_replaced: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(res_reg.hit && res_reg.was_replaced))
        else $error("result flags both hit and replacement");
`endif

endmodule
